/* rtl/core/cse_pkg.sv */
// Column statistics engine: shared widths, item structs, unit requests and
// the control state encoding. No dependencies.
`default_nettype none

package cse_pkg;

    localparam int VALUE_W   = 16;
    localparam int MAX_ITEMS = 1048576;

    // count holds 0..MAX_ITEMS
    localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
    // running sum and sum of squares over at most MAX_ITEMS values
    localparam int SUM_W   = VALUE_W + COUNT_W;
    localparam int SQ_W    = 2 * VALUE_W + COUNT_W - 2;
    // magnitude of the sum, the divider's dividend
    localparam int DIVD_W  = SUM_W - 1;
    // n*avg - 2*sum, the second multiplicand
    localparam int MC_W    = VALUE_W + COUNT_W + 1;
    localparam int PROD_W  = MC_W + VALUE_W;
    // summed squared deviations, below MAX_ITEMS * 2^(2*VALUE_W)
    localparam int DEV_W   = 2 * VALUE_W + COUNT_W - 1;
    localparam int FRAC_W  = 8;
    localparam int ROOT_W  = DEV_W / 2 + FRAC_W;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic signed [VALUE_W-1:0] max_value;
        logic signed [VALUE_W-1:0] average_value;
        logic [ROOT_W-1:0]         deviation_root;
        logic                      ascending;
        logic                      descending;
        logic                      dense_from_zero;
        logic                      count_overflow;
    } out_item_t;

    typedef struct packed {
        logic                    start;
        logic signed [MC_W-1:0]  mcand;
        logic [VALUE_W-1:0]      mplier;
    } mul_req_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [COUNT_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic             start;
        logic [DEV_W-1:0] radicand;
    } sqrt_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV,
        ST_MUL_NA,
        ST_MUL_AU,
        ST_ROOT,
        ST_EMIT
    } cse_state_t;

endpackage

`default_nettype wire

/* rtl/core/cse_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on cse_pkg.
`default_nettype none

module cse_mul
    import cse_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire mul_req_t                 req,
    output logic                          done,
    output logic signed [PROD_W-1:0]      prod
);

    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic signed [PROD_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] mc_reg;
    logic [VALUE_W-1:0]       mp_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                acc_reg  <= '0;
                mc_reg   <= {{(PROD_W-MC_W){req.mcand[MC_W-1]}}, req.mcand};
                mp_reg   <= req.mplier;
                cnt_reg  <= CNT_W'(VALUE_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (mp_reg[0]) begin
                    acc_reg <= acc_reg + mc_reg;
                end
                mc_reg  <= mc_reg <<< 1;
                mp_reg  <= mp_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/cse_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend over an
// unsigned nonzero divisor, quotient truncated toward zero. Depends on cse_pkg.
`default_nettype none

module cse_div
    import cse_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire div_req_t           req,
    output logic                    done,
    output logic [VALUE_W-1:0]      q_mag,
    output logic                    q_neg
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [COUNT_W-1:0] rem_reg;
    logic [DIVD_W-1:0]  dq_reg;
    logic [COUNT_W-1:0] dvs_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic signed [SUM_W-1:0] dvd_abs;
    logic [COUNT_W:0]        rem_sh;
    logic [COUNT_W:0]        diff;

    always_comb begin
        dvd_abs = req.dividend[SUM_W-1] ? -req.dividend : req.dividend;
        rem_sh  = {rem_reg, dq_reg[DIVD_W-1]};
        diff    = rem_sh - {1'b0, dvs_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= '0;
                dq_reg   <= dvd_abs[DIVD_W-1:0];
                dvs_reg  <= req.divisor;
                neg_reg  <= req.dividend[SUM_W-1];
                cnt_reg  <= CNT_W'(DIVD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[COUNT_W]) begin
                    rem_reg <= diff[COUNT_W-1:0];
                    dq_reg  <= {dq_reg[DIVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh[COUNT_W-1:0];
                    dq_reg  <= {dq_reg[DIVD_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // |sum| / count never exceeds 2^(VALUE_W-1)
    assign done  = done_reg;
    assign q_mag = dq_reg[VALUE_W-1:0];
    assign q_neg = neg_reg;

endmodule

`default_nettype wire

/* rtl/core/cse_sqrt.sv */
// Digit-by-digit square root, one radicand bit pair per cycle, with FRAC_W
// zero pairs appended for the fraction bits. Depends on cse_pkg.
`default_nettype none

module cse_sqrt
    import cse_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sqrt_req_t         req,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [DEV_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[DEV_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        diff   = {1'b0, rem_sh} - {1'b0, trial};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rad_reg  <= req.radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!diff[REM_W]) begin
                    rem_reg  <= diff[REM_W-1:0];
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                rad_reg <= {rad_reg[DEV_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* rtl/core/column_statistics_engine.sv */
// Column statistics engine top level: accumulators, control sequencer and
// output register. Depends on cse_pkg, cse_mul, cse_div and cse_sqrt.
//
// Usage:
//   s_valid/s_ready/s_item carry one column value per item; last_value marks
//   the column's final value. m_valid/m_ready/m_item carry one result per
//   column: min, max, truncated average, root of summed squared deviations
//   (8 fraction bits) and the ascending, descending, dense and overflow flags.
// Input:
//   A counted item's square is formed by the bit-serial multiplier, one
//   multiplier bit per cycle, before s_ready returns. Items beyond
//   MAX_ITEMS only touch min/max/flags and skip the square.
// Last item to m_valid: the square (for a counted item), a 36-bit serial
//   divide, two 16-bit serial multiplies for n*avg and
//   avg*(n*avg - 2*sum), a 34-step root, then the output load.
// Reset: synchronous, active low; accumulators return to their empty-column
//   values and m_valid drops. After each result the accumulators clear too.
// Stall: the result sits in the output register while m_ready is low; the
//   next column streams in meanwhile, and its own result waits for the
//   register to free up before loading.
`default_nettype none

module column_statistics_engine
    import cse_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    localparam logic signed [VALUE_W-1:0] MIN_INIT = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] MAX_INIT = {1'b1, {(VALUE_W-1){1'b0}}};

    cse_state_t state_reg, state_next;

    // running statistics
    logic signed [VALUE_W-1:0] min_reg, max_reg, prev_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      asc_reg, desc_reg, dense_reg, ovf_reg;
    logic                      last_reg;

    // truncated average as sign and magnitude
    logic [VALUE_W-1:0]        avg_mag_reg;
    logic                      avg_neg_reg;

    out_item_t                 out_reg;
    logic                      out_valid_reg;

    // unit handshakes
    mul_req_t                  mul_req;
    div_req_t                  div_req;
    sqrt_req_t                 sqrt_req;
    logic                      mul_done, div_done, sqrt_done;
    logic signed [PROD_W-1:0]  mul_prod;
    logic [VALUE_W-1:0]        div_q_mag;
    logic                      div_q_neg;
    logic [ROOT_W-1:0]         sqrt_root;

    logic                      s_accept;
    logic                      in_range;
    logic                      first_item;
    logic signed [VALUE_W-1:0] v;
    logic [VALUE_W-1:0]        v_mag;
    logic signed [VALUE_W:0]   v_ext, prev_inc;
    logic signed [PROD_W-1:0]  prod_signed;
    logic signed [MC_W-1:0]    sum_ext;
    logic signed [MC_W-1:0]    na_minus_2s;
    logic signed [PROD_W-1:0]  dev_full;
    logic                      out_load;

    cse_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    cse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .q_mag   (div_q_mag),
        .q_neg   (div_q_neg)
    );

    cse_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign in_range = (count_reg < COUNT_W'(MAX_ITEMS));
    assign first_item = (count_reg == '0);

    always_comb begin
        v        = s_item.value;
        v_mag    = v[VALUE_W-1] ? VALUE_W'(-v) : VALUE_W'(v);
        v_ext    = {v[VALUE_W-1], v};
        prev_inc = {prev_reg[VALUE_W-1], prev_reg} + 1'b1;

        // the serial multiplier works on |avg|; restore the sign here
        prod_signed = avg_neg_reg ? -mul_prod : mul_prod;
        sum_ext     = {{(MC_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
        na_minus_2s = prod_signed[MC_W-1:0] - (sum_ext <<< 1);
        // sum (x - a)^2 = sq + a * (n*a - 2*sum), exact and non-negative
        dev_full    = {{(PROD_W-SQ_W){1'b0}}, sq_reg} + prod_signed;
    end

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);

    // sequencer: next state and unit start requests
    always_comb begin
        state_next        = state_reg;
        mul_req.start     = 1'b0;
        mul_req.mcand     = MC_W'(v_mag);
        mul_req.mplier    = v_mag;
        div_req.start     = 1'b0;
        div_req.dividend  = sum_reg;
        div_req.divisor   = count_reg;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = dev_full[DEV_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_range) begin
                        mul_req.start = 1'b1;
                        state_next    = ST_SQUARE;
                    end else if (s_item.last_value) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_SQUARE: begin
                if (mul_done) begin
                    if (last_reg) begin
                        div_req.start = 1'b1;
                        state_next    = ST_DIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = MC_W'(count_reg);
                    mul_req.mplier = div_q_mag;
                    state_next     = ST_MUL_NA;
                end
            end
            ST_MUL_NA: begin
                if (mul_done) begin
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = na_minus_2s;
                    mul_req.mplier = avg_mag_reg;
                    state_next     = ST_MUL_AU;
                end
            end
            ST_MUL_AU: begin
                if (mul_done) begin
                    sqrt_req.start = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= MIN_INIT;
            max_reg       <= MAX_INIT;
            prev_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            count_reg     <= '0;
            asc_reg       <= 1'b1;
            desc_reg      <= 1'b1;
            dense_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                if (v < min_reg) begin
                    min_reg <= v;
                end
                if (v > max_reg) begin
                    max_reg <= v;
                end
                if (first_item) begin
                    if (v != '0) begin
                        dense_reg <= 1'b0;
                    end
                end else begin
                    if (v < prev_reg) begin
                        asc_reg <= 1'b0;
                    end
                    if (v > prev_reg) begin
                        desc_reg <= 1'b0;
                    end
                    // no wrap: the largest value then the most negative fails
                    if (v_ext != prev_inc) begin
                        dense_reg <= 1'b0;
                    end
                end
                prev_reg <= v;
                last_reg <= s_item.last_value;
                if (in_range) begin
                    sum_reg   <= sum_reg + {{(SUM_W-VALUE_W){v[VALUE_W-1]}}, v};
                    count_reg <= count_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_SQUARE) && mul_done) begin
                sq_reg <= sq_reg + mul_prod[SQ_W-1:0];
            end

            if ((state_reg == ST_DIV) && div_done) begin
                avg_mag_reg <= div_q_mag;
                avg_neg_reg <= div_q_neg;
            end

            if (out_load) begin
                out_reg.min_value       <= min_reg;
                out_reg.max_value       <= max_reg;
                out_reg.average_value   <= avg_neg_reg ? -avg_mag_reg : avg_mag_reg;
                out_reg.deviation_root  <= sqrt_root;
                out_reg.ascending       <= asc_reg;
                out_reg.descending      <= desc_reg;
                out_reg.dense_from_zero <= dense_reg;
                out_reg.count_overflow  <= ovf_reg;
                // column done: back to empty-column values
                min_reg   <= MIN_INIT;
                max_reg   <= MAX_INIT;
                prev_reg  <= '0;
                sum_reg   <= '0;
                sq_reg    <= '0;
                count_reg <= '0;
                asc_reg   <= 1'b1;
                desc_reg  <= 1'b1;
                dense_reg <= 1'b1;
                ovf_reg   <= 1'b0;
                last_reg  <= 1'b0;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

`default_nettype wire

/* rtl/core/cse_checker.sv */
// Port-level checks for column_statistics_engine, attached by bind.
// Depends on cse_pkg.
`default_nettype none

module cse_checker
    import cse_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_item,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_item
);

    // output register empties on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed under stall");

    // the column's last item starts the final computation
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.last_value |=> !s_ready)
        else $error("input ready right after last item");

    // min <= average <= max
    a_avg_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_item.min_value) <= $signed(m_item.average_value))
                 && ($signed(m_item.average_value) <= $signed(m_item.max_value)))
        else $error("average outside min/max");

    // a dense column is non-decreasing
    a_dense_asc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.dense_from_zero |-> m_item.ascending)
        else $error("dense column not ascending");

endmodule

bind column_statistics_engine cse_checker u_cse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for column_statistics_engine: directed and random columns,
// checked against a built-in predictor. Depends on cse_pkg and the engine RTL.

module tb
    import cse_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    // Running column state plus the queue of column results still owed.
    class column_tally;
        logic signed [VALUE_W-1:0] lowest, highest, prior;
        longint value_sum, square_sum;
        int unsigned seen;
        bit rising, falling, counting_up, saturated;
        out_item_t pending_results[$];
        int errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            lowest = MOST_POS;
            highest = MOST_NEG;
            prior = '0;
            value_sum = 0;
            square_sum = 0;
            seen = 0;
            rising = 1;
            falling = 1;
            counting_up = 1;
            saturated = 0;
        endfunction

        // floor(256 * sqrt(d)) by bitwise search on d << 16
        function automatic logic [33:0] scaled_root(longint unsigned d);
            logic [127:0] radicand, trial_sq;
            logic [63:0] root, trial;
            radicand = {64'd0, d} << 16;
            root = '0;
            for (int b = 47; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                trial_sq = {64'd0, trial} * {64'd0, trial};
                if (trial_sq <= radicand) root = trial;
            end
            return root[33:0];
        endfunction

        function void note_value(in_item_t it);
            longint v, avg, dev;
            out_item_t res;
            v = longint'(it.value);
            if (it.value < lowest) lowest = it.value;
            if (it.value > highest) highest = it.value;
            if (seen == 0) begin
                if (v != 0) counting_up = 0;
            end else begin
                if (v < longint'(prior)) rising = 0;
                if (v > longint'(prior)) falling = 0;
                if (v != longint'(prior) + 1) counting_up = 0;
            end
            prior = it.value;
            if (seen >= MAX_ITEMS) begin
                saturated = 1;
            end else begin
                value_sum += v;
                square_sum += v * v;
                seen++;
            end
            if (!it.last_value) return;
            avg = value_sum / longint'(seen);
            dev = square_sum - 2 * avg * value_sum + longint'(seen) * avg * avg;
            res.min_value = lowest;
            res.max_value = highest;
            res.average_value = avg[VALUE_W-1:0];
            res.deviation_root = scaled_root(dev);
            res.ascending = rising;
            res.descending = falling;
            res.dense_from_zero = counting_up;
            res.count_overflow = saturated;
            pending_results.push_back(res);
            clear();
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.min_value !== want.min_value)
                report_mismatch("min_value", got.min_value, want.min_value);
            if (got.max_value !== want.max_value)
                report_mismatch("max_value", got.max_value, want.max_value);
            if (got.average_value !== want.average_value)
                report_mismatch("average_value", got.average_value, want.average_value);
            if (got.deviation_root !== want.deviation_root)
                report_mismatch("deviation_root", got.deviation_root, want.deviation_root);
            if (got.ascending !== want.ascending)
                report_mismatch("ascending", got.ascending, want.ascending);
            if (got.descending !== want.descending)
                report_mismatch("descending", got.descending, want.descending);
            if (got.dense_from_zero !== want.dense_from_zero)
                report_mismatch("dense_from_zero", got.dense_from_zero, want.dense_from_zero);
            if (got.count_overflow !== want.count_overflow)
                report_mismatch("count_overflow", got.count_overflow, want.count_overflow);
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned values_sent = 0;
    int unsigned cycle_count = 0;
    logic signed [VALUE_W-1:0] column_buf[$];

    column_tally tally = new();

    column_statistics_engine i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #4 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // results are sampled at the edge where they are taken
    always @(posedge aclk) begin
        if (m_valid && m_ready) tally.check_result(m_item);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    task send_value(logic signed [VALUE_W-1:0] v, logic last);
        in_item_t it;
        it.value = v;
        it.last_value = last;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        tally.note_value(it);
        values_sent++;
    endtask

    task send_column();
        for (int i = 0; i < column_buf.size(); i++)
            send_value(column_buf[i], i == column_buf.size() - 1);
        column_buf.delete();
    endtask

    // Well-formed shapes (sorted, dense, constant) with random content,
    // plus fully random and broken columns.
    task random_column();
        int len, shape, walk, step;
        len = ($urandom_range(99) < 90) ? $urandom_range(1, 10) : $urandom_range(20, 60);
        shape = $urandom_range(0, 9);
        walk = int'($urandom_range(0, 65535)) - 32768;
        for (int i = 0; i < len; i++) begin
            case (shape)
                0, 1: column_buf.push_back(VALUE_W'($urandom()));
                2: column_buf.push_back(VALUE_W'(int'($urandom_range(0, 16)) - 8));
                3: begin
                    column_buf.push_back(VALUE_W'(walk));
                    step = $urandom_range(0, 3);
                    walk = (walk + step > 32767) ? 32767 : walk + step;
                end
                4: begin
                    column_buf.push_back(VALUE_W'(walk));
                    step = $urandom_range(0, 3);
                    walk = (walk - step < -32768) ? -32768 : walk - step;
                end
                5: column_buf.push_back(VALUE_W'(i));
                6: column_buf.push_back(VALUE_W'((i == len / 2) ? i + 1 : i));
                7: column_buf.push_back(VALUE_W'(walk));
                8: begin
                    case ($urandom_range(0, 3))
                        0: column_buf.push_back(MOST_NEG);
                        1: column_buf.push_back(VALUE_W'(MOST_NEG + 1));
                        2: column_buf.push_back(VALUE_W'(MOST_POS - 1));
                        default: column_buf.push_back(MOST_POS);
                    endcase
                end
                default: column_buf.push_back(VALUE_W'(32765 + i)); // runs through the wrap
            endcase
        end
        send_column();
    endtask

    initial begin
        send_idle_pct = 28;
        recv_stall_pct = 78;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lone elements: zero is dense, extremes are not
        send_value(0, 1);
        send_value(MOST_NEG, 1);
        send_value(MOST_POS, 1);
        // dense from zero
        column_buf = '{0, 1, 2, 3};
        send_column();
        // largest then most negative is not consecutive
        column_buf = '{MOST_POS, MOST_NEG};
        send_column();
        // alternating extremes, largest deviation
        column_buf = '{MOST_NEG, MOST_POS, MOST_NEG, MOST_POS};
        send_column();
        // negative average truncates toward zero
        column_buf = '{-3, -4};
        send_column();
        // non-increasing with a repeat
        column_buf = '{5, 5, 2, -1};
        send_column();
        // constant, zero deviation
        column_buf = '{MOST_NEG, MOST_NEG, MOST_NEG};
        send_column();

        values_sent = 0;
        while (values_sent < 135) random_column();
        send_idle_pct = 78;
        recv_stall_pct = 28;
        while (values_sent < 270) random_column();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (values_sent < 400) random_column();

        s_valid <= 1'b0;
        while (tally.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tally.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
